>>> rtl/websocket_frame_encoder_top_defines.svh
// Assertion macros used by the encoder top level.
`ifndef WEBSOCKET_FRAME_ENCODER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WSFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WSFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/wsfe_pkg.sv
package wsfe_pkg;

   localparam int unsigned LEN_W = 63;

   localparam logic [7:0] FIN_BIT        = 8'h80;
   localparam logic [7:0] MASK_BIT       = 8'h80;
   localparam logic [6:0] LEN_MID_CODE   = 7'd126;
   localparam logic [6:0] LEN_LONG_CODE  = 7'd127;
   localparam logic [LEN_W-1:0] LEN_SHORT_LIMIT = LEN_W'(126);
   localparam logic [LEN_W-1:0] LEN_MID_MAX     = LEN_W'(65535);
   localparam logic [31:0] KEY_RESET    = 32'h0102_0304;

   localparam logic [3:0] SHORT_LAST_IDX = 4'd5;
   localparam logic [3:0] MID_LAST_IDX   = 4'd7;
   localparam logic [3:0] LONG_LAST_IDX  = 4'd13;
   localparam logic [3:0] SHORT_KEY_IDX  = 4'd2;
   localparam logic [3:0] MID_KEY_IDX    = 4'd4;
   localparam logic [3:0] LONG_KEY_IDX   = 4'd10;

   typedef enum logic [1:0] {
      CMD_HEADER = 2'd0,
      CMD_DATA   = 2'd1,
      CMD_DROP   = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      LEN_SHORT = 2'd0,
      LEN_MID   = 2'd1,
      LEN_LONG  = 2'd2
   } len_class_type;

   typedef struct packed {
      cmd_kind_type     kind;
      len_class_type    len_class;
      logic [3:0]       opcode;
      logic [LEN_W-1:0] length;
      logic [7:0]       data;
      logic             frame_end;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_stat_type;

   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0: b = key[31:24];
         2'd1: b = key[23:16];
         2'd2: b = key[15:8];
         2'd3: b = key[7:0];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

endpackage

>>> rtl/wsfe_front.sv
module wsfe_front
   import wsfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_start_frame,
   input  logic [3:0]           req_frame_opcode,
   input  logic [LEN_W-1:0]     req_frame_len,
   input  logic [7:0]           req_data_byte,
   input  logic [31:0]          cur_key,
   input  q_stat_type           q_stat,
   output logic                 push,
   output cmd_type              push_cmd
);

   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [1:0]       pos_ff, pos_in;
   logic             open_frame;

   assign req_stall  = q_stat.full;
   assign push       = req_valid && !q_stat.full;
   assign open_frame = (remain_ff != '0);

   always_comb begin
      push_cmd           = '0;
      push_cmd.opcode    = req_frame_opcode;
      push_cmd.length    = req_frame_len;
      remain_in          = remain_ff;
      pos_in             = pos_ff;
      if (req_start_frame) begin
         push_cmd.kind = CMD_HEADER;
         if (req_frame_len < LEN_SHORT_LIMIT) begin
            push_cmd.len_class = LEN_SHORT;
         end else if (req_frame_len <= LEN_MID_MAX) begin
            push_cmd.len_class = LEN_MID;
         end else begin
            push_cmd.len_class = LEN_LONG;
         end
         push_cmd.frame_end = (req_frame_len == '0);
         remain_in          = req_frame_len;
         pos_in             = 2'd0;
      end else if (!open_frame) begin
         push_cmd.kind = CMD_DROP;
      end else begin
         push_cmd.kind      = CMD_DATA;
         push_cmd.data      = req_data_byte ^ key_byte(cur_key, pos_ff);
         push_cmd.frame_end = (remain_ff == LEN_W'(1));
         remain_in          = remain_ff - LEN_W'(1);
         pos_in             = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         pos_ff    <= 2'd0;
      end else if (push) begin
         remain_ff <= remain_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

>>> rtl/wsfe_queue.sv
module wsfe_queue
   import wsfe_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output cmd_type    head_cmd,
   output q_stat_type q_stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_stat.full      = (count_ff == CNT_W'(DEPTH));
   assign q_stat.not_empty = (count_ff != '0);
   assign do_push          = push && !q_stat.full;
   assign do_pop           = pop && q_stat.not_empty;
   assign head_cmd         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/wsfe_back.sv
module wsfe_back
   import wsfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  q_stat_type  q_stat,
   input  cmd_type     head_cmd,
   input  logic [31:0] cur_key,
   output logic        pop,
   output logic [3:0]  hdr_idx,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_end,
   output logic        rsp_order_error
);

   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        fend_ff, fend_in;
   logic        err_ff, err_in;

   logic        out_free, emit;
   logic [3:0]  last_idx, key_idx, len_pos;
   logic [63:0] len_wide;
   logic [7:0]  hdr_byte, len_code;

   assign out_free = !valid_ff || !rsp_stall;
   assign emit     = q_stat.not_empty && out_free;
   assign len_wide = {1'b0, head_cmd.length};
   assign len_pos  = key_idx - idx_ff - 4'd1;

   always_comb begin
      unique case (head_cmd.len_class)
         LEN_SHORT: begin
            last_idx = SHORT_LAST_IDX;
            key_idx  = SHORT_KEY_IDX;
            len_code = MASK_BIT | {1'b0, head_cmd.length[6:0]};
         end
         LEN_MID: begin
            last_idx = MID_LAST_IDX;
            key_idx  = MID_KEY_IDX;
            len_code = MASK_BIT | {1'b0, LEN_MID_CODE};
         end
         LEN_LONG: begin
            last_idx = LONG_LAST_IDX;
            key_idx  = LONG_KEY_IDX;
            len_code = MASK_BIT | {1'b0, LEN_LONG_CODE};
         end
         default: begin
            last_idx = LONG_LAST_IDX;
            key_idx  = LONG_KEY_IDX;
            len_code = MASK_BIT | {1'b0, LEN_LONG_CODE};
         end
      endcase
   end

   always_comb begin
      priority if (idx_ff == 4'd0) begin
         hdr_byte = FIN_BIT | {4'd0, head_cmd.opcode};
      end else if (idx_ff == 4'd1) begin
         hdr_byte = len_code;
      end else if (idx_ff < key_idx) begin
         hdr_byte = len_wide[{len_pos[2:0], 3'b000} +: 8];
      end else begin
         hdr_byte = key_byte(cur_key, 2'(idx_ff - key_idx));
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      pop      = 1'b0;
      valid_in = valid_ff && rsp_stall;
      byte_in  = byte_ff;
      last_in  = last_ff;
      fend_in  = fend_ff;
      err_in   = err_ff;
      if (emit) begin
         valid_in = 1'b1;
         unique case (head_cmd.kind)
            CMD_HEADER: begin
               byte_in = hdr_byte;
               last_in = (idx_ff == last_idx);
               fend_in = (idx_ff == last_idx) && head_cmd.frame_end;
               err_in  = 1'b0;
               if (idx_ff == last_idx) begin
                  pop    = 1'b1;
                  idx_in = 4'd0;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            CMD_DATA: begin
               byte_in = head_cmd.data;
               last_in = 1'b1;
               fend_in = head_cmd.frame_end;
               err_in  = 1'b0;
               pop     = 1'b1;
            end
            default: begin
               byte_in = 8'd0;
               last_in = 1'b1;
               fend_in = 1'b0;
               err_in  = 1'b1;
               pop     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      fend_ff <= fend_in;
      err_ff  <= err_in;
   end

   assign hdr_idx         = idx_ff;
   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_frame_end   = fend_ff;
   assign rsp_order_error = err_ff;

endmodule

>>> rtl/websocket_frame_encoder_top.sv
// Channel   Direction  Handshake         Beat content
// req_      in         req_valid/stall   start_frame, frame_opcode, frame_len, data_byte
// rsp_      out        rsp_valid/stall   out_byte, run_last, frame_end, order_error
// csr_      in         csr_wr_en         masking key (32 bits)
//
// A payload beat gives one output byte; it is registered in the command queue, then in the output register.
// A frame start gives 6, 8 or 14 output bytes, one per cycle from the back-end sequencer while rsp_ is not stalled.
// The command queue (QUEUE_DEPTH entries) lets payload beats enter while a header drains.
// Reset is synchronous; it closes any open frame and loads the key 0x01020304.
// A stall on rsp_ holds the output register; req_stall rises only when the queue is full.
`include "websocket_frame_encoder_top_defines.svh"

module websocket_frame_encoder_top
   import wsfe_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_start_frame,
   input  logic [3:0]       req_frame_opcode,
   input  logic [LEN_W-1:0] req_frame_len,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_frame_end,
   output logic             rsp_order_error,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   logic [31:0] key_ff;
   q_stat_type  q_stat;
   cmd_type     push_cmd, head_cmd;
   logic        push, pop;
   logic [3:0]  hdr_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else if (csr_wr_en) begin
         key_ff <= csr_wr_data;
      end
   end

   wsfe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_frame    (req_start_frame),
      .req_frame_opcode   (req_frame_opcode),
      .req_frame_len      (req_frame_len),
      .req_data_byte      (req_data_byte),
      .cur_key            (key_ff),
      .q_stat             (q_stat),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   wsfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   wsfe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .head_cmd        (head_cmd),
      .cur_key         (key_ff),
      .pop             (pop),
      .hdr_idx         (hdr_idx),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_order_error (rsp_order_error)
   );

   `WSFE_ASSERT_NEXT(a_accept_fills_queue, clock, reset, req_valid && !req_stall, q_stat.not_empty, "accepted beat missing from queue")
   `WSFE_ASSERT_NOW(a_drop_beat_shape, clock, reset, rsp_valid && rsp_order_error, rsp_run_last && !rsp_frame_end && (rsp_out_byte == 8'd0), "malformed drop beat")
   `WSFE_ASSERT_NOW(a_hdr_idx_range, clock, reset, 1'b1, hdr_idx <= LONG_LAST_IDX, "header index out of range")

endmodule
